// ===== sv/cwz_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cwz_pkg: shared types and constants for the zoned calendar clock
// Field widths, function codes, register indexes and calendar helpers.
// ----------------------------------------------------------------------------
package cwz_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    typedef logic [13:0]        year_t;
    typedef logic [3:0]         month_t;
    typedef logic [4:0]         day_t;
    typedef logic [4:0]         hour_t;
    typedef logic [5:0]         minsec_t;
    typedef logic signed [4:0]  offset_t;

    // Function codes of an input beat
    localparam logic [1:0] FUNC_TICK = 2'd0;
    localparam logic [1:0] FUNC_LOAD = 2'd1;
    localparam logic [1:0] FUNC_ZONE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ZONE_A = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ZONE_B = 1'b1;

    localparam year_t   YEAR_MIN     = 14'd1;
    localparam year_t   YEAR_MAX     = 14'd9999;
    localparam year_t   YEAR_RESET   = 14'd2020;
    localparam month_t  MONTH_JAN    = 4'd1;
    localparam month_t  MONTH_MAR    = 4'd3;
    localparam month_t  MONTH_DEC    = 4'd12;
    localparam day_t    DAY_FIRST    = 5'd1;
    localparam day_t    DAY_DEC_LEN  = 5'd31;
    localparam hour_t   HOUR_MAX     = 5'd23;
    localparam minsec_t MINSEC_MAX   = 6'd59;
    localparam offset_t ZONE_B_RESET = -5'sd6;
    localparam logic [2:0] WEEK_SUNDAY = 3'd7;

    // Divisibility by 25: y is a multiple of 25 exactly when y times the
    // inverse of 25 modulo 2^14 lands at or below (2^14 - 1) / 25.
    localparam year_t INV25       = 14'd7209;
    localparam year_t DIV25_LIMIT = 14'd655;

    // floor(x / 25) for x below 4096 is (x * 5243) >> 17
    localparam logic [12:0] RECIP25       = 13'd5243;
    localparam int          RECIP25_SHIFT = 17;

    // Day-of-week month offsets, January first
    localparam logic [2:0] MONTH_SHIFT [12] = '{
        3'd0, 3'd3, 3'd2, 3'd5, 3'd0, 3'd3, 3'd5, 3'd1, 3'd4, 3'd6, 3'd2, 3'd4
    };

    typedef struct packed {
        logic [1:0] func;
        year_t      load_year;
        month_t     load_month;
        day_t       load_day;
        hour_t      load_hour;
        minsec_t    load_minute;
        minsec_t    load_second;
    } item_t;

    typedef struct packed {
        year_t      local_year;
        month_t     local_month;
        day_t       local_day;
        hour_t      local_hour;
        minsec_t    local_minute;
        minsec_t    local_second;
        logic [2:0] week_day;
        logic       zone_index;
    } result_t;

    function automatic logic is_leap(input year_t y);
        year_t scaled;
        logic  div25;
        scaled = y * INV25;
        div25  = (scaled <= DIV25_LIMIT);
        return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
    endfunction

    function automatic day_t month_len(input month_t m, input logic leap);
        day_t len;
        case (m) inside
            4'd2:                    len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

endpackage
`default_nettype wire

// ===== sv/cwz_item_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cwz_item_if: input channel of the zoned calendar clock
// Valid/ready handshake carrying one tick, load or zone-step command.
// ----------------------------------------------------------------------------
interface cwz_item_if;
    import cwz_pkg::*;

    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/cwz_result_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cwz_result_if: result channel of the zoned calendar clock
// Valid/ready handshake carrying the local date, time and weekday.
// ----------------------------------------------------------------------------
interface cwz_result_if;
    import cwz_pkg::*;

    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/calendar_clock_with_zones.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// calendar_clock_with_zones: Gregorian clock with two time zones
// Counts seconds through years with leap years, loads date and time, and
// reports the time shifted by the selected zone's hour offset with weekday.
// ----------------------------------------------------------------------------
//  channel   dir  handshake           beat contents
//  item      in   valid/ready         func, load_year .. load_second
//  result    out  valid/ready         local date/time, week_day, zone_index
//  cfg       in   cfg_write_en        cfg_index selects zone offset, cfg_data
//
//  One beat in and one beat out per cycle while the result side is ready; a
//  result passes the state update, zone shift, century divide and weekday
//  sum registers after the edge that takes its item. Reset loads 2020-01-01
//  00:00:00, zone 0, offsets 0 and -6. A stalled result holds the pipeline;
//  item.ready drops only once every stage holds a beat.
// ----------------------------------------------------------------------------
module calendar_clock_with_zones (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write_en,
    input  logic [cwz_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cwz_pkg::CFG_DATA_W-1:0]   cfg_data,
    cwz_item_if.sink                         item,
    cwz_result_if.source                     result
);
    import cwz_pkg::*;

    // Handshake
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s1_valid_next, s2_valid_next, s3_valid_next, s4_valid_next;
    logic s2_ready, s3_ready, s4_ready;
    logic s2_load, s3_load, s4_load;
    logic item_fire;

    // Configuration
    offset_t zone_a_reg, zone_b_reg;

    // Calendar state
    year_t   year_reg,   year_next;
    month_t  month_reg,  month_next;
    day_t    day_reg,    day_next;
    hour_t   hour_reg,   hour_next;
    minsec_t minute_reg, minute_next;
    minsec_t second_reg, second_next;
    logic    zone_sel_reg, zone_sel_next;

    // Stage 1 helpers
    year_t  ld_year, cal_year;
    month_t ld_month, cal_month;
    day_t   ld_day, cal_len;
    hour_t  ld_hour;
    minsec_t ld_minute, ld_second;
    logic   is_load;

    // Stage 2: zone shift
    offset_t          offset;
    logic signed [6:0] hour_sum;
    logic             leap_cur;
    day_t             len_cur, len_prev;
    result_t          loc;
    result_t          s2_res_reg;

    // Stage 3: century divide
    year_t       yy;
    logic [24:0] q100_prod;
    result_t     s3_res_reg;
    year_t       s3_yy_reg;
    logic [7:0]  s3_q100_reg;

    // Stage 4: weekday
    logic [14:0] dow_sum;
    logic [5:0]  fold1;
    logic [3:0]  fold2;
    logic [2:0]  dow_rem;
    result_t     s4_res_next;
    result_t     s4_res_reg;

    localparam logic signed [6:0] HOURS_PER_DAY = 7'sd24;

    // ---------------------------------------------------------------- handshake
    assign s4_ready   = !s4_valid_reg || result.ready;
    assign s3_ready   = !s3_valid_reg || s4_ready;
    assign s2_ready   = !s2_valid_reg || s3_ready;
    assign item.ready = !s1_valid_reg || s2_ready;
    assign item_fire  = item.valid && item.ready;

    assign s2_load = s1_valid_reg && s2_ready;
    assign s3_load = s2_valid_reg && s3_ready;
    assign s4_load = s3_valid_reg && s4_ready;

    assign s1_valid_next = item_fire || (s1_valid_reg && !s2_ready);
    assign s2_valid_next = s2_load   || (s2_valid_reg && !s3_ready);
    assign s3_valid_next = s3_load   || (s3_valid_reg && !s4_ready);
    assign s4_valid_next = s4_load   || (s4_valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
            s4_valid_reg <= s4_valid_next;
        end
    end

    // ------------------------------------------------------------ configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_a_reg <= '0;
            zone_b_reg <= ZONE_B_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_ZONE_A: zone_a_reg <= cfg_data;
                REG_ZONE_B: zone_b_reg <= cfg_data;
            endcase
        end
    end

    // -------------------------------------------------- stage 1: calendar state
    always_comb
    begin
        is_load = (item.data.func == FUNC_LOAD);

        ld_year = (item.data.load_year < YEAR_MIN) ? YEAR_MIN :
                  (item.data.load_year > YEAR_MAX) ? YEAR_MAX : item.data.load_year;
        ld_month = (item.data.load_month < MONTH_JAN) ? MONTH_JAN :
                   (item.data.load_month > MONTH_DEC) ? MONTH_DEC : item.data.load_month;

        // One month length serves both the clamp of a load and the tick carry
        cal_year  = is_load ? ld_year  : year_reg;
        cal_month = is_load ? ld_month : month_reg;
        cal_len   = month_len(cal_month, is_leap(cal_year));

        ld_day = (item.data.load_day < DAY_FIRST) ? DAY_FIRST :
                 (item.data.load_day > cal_len) ? cal_len : item.data.load_day;
        ld_hour   = (item.data.load_hour > HOUR_MAX) ? HOUR_MAX : item.data.load_hour;
        ld_minute = (item.data.load_minute > MINSEC_MAX) ? MINSEC_MAX
                                                         : item.data.load_minute;
        ld_second = (item.data.load_second > MINSEC_MAX) ? MINSEC_MAX
                                                         : item.data.load_second;

        year_next     = year_reg;
        month_next    = month_reg;
        day_next      = day_reg;
        hour_next     = hour_reg;
        minute_next   = minute_reg;
        second_next   = second_reg;
        zone_sel_next = zone_sel_reg;

        if (item_fire)
        begin
            case (item.data.func)
                FUNC_TICK:
                begin
                    if (second_reg >= MINSEC_MAX)
                    begin
                        second_next = '0;
                        if (minute_reg >= MINSEC_MAX)
                        begin
                            minute_next = '0;
                            if (hour_reg >= HOUR_MAX)
                            begin
                                hour_next = '0;
                                if (day_reg >= cal_len)
                                begin
                                    day_next = DAY_FIRST;
                                    if (month_reg >= MONTH_DEC)
                                    begin
                                        month_next = MONTH_JAN;
                                        // hold the year at its top value
                                        if (year_reg < YEAR_MAX)
                                        begin
                                            year_next = year_reg + 14'd1;
                                        end
                                    end
                                    else
                                    begin
                                        month_next = month_reg + 4'd1;
                                    end
                                end
                                else
                                begin
                                    day_next = day_reg + 5'd1;
                                end
                            end
                            else
                            begin
                                hour_next = hour_reg + 5'd1;
                            end
                        end
                        else
                        begin
                            minute_next = minute_reg + 6'd1;
                        end
                    end
                    else
                    begin
                        second_next = second_reg + 6'd1;
                    end
                end
                FUNC_LOAD:
                begin
                    year_next   = ld_year;
                    month_next  = ld_month;
                    day_next    = ld_day;
                    hour_next   = ld_hour;
                    minute_next = ld_minute;
                    second_next = ld_second;
                end
                FUNC_ZONE:
                begin
                    zone_sel_next = !zone_sel_reg;
                end
                default:
                begin
                    // unused code: state holds, a result still goes out
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_reg     <= YEAR_RESET;
            month_reg    <= MONTH_JAN;
            day_reg      <= DAY_FIRST;
            hour_reg     <= '0;
            minute_reg   <= '0;
            second_reg   <= '0;
            zone_sel_reg <= 1'b0;
        end
        else
        begin
            year_reg     <= year_next;
            month_reg    <= month_next;
            day_reg      <= day_next;
            hour_reg     <= hour_next;
            minute_reg   <= minute_next;
            second_reg   <= second_next;
            zone_sel_reg <= zone_sel_next;
        end
    end

    // ------------------------------------------------------ stage 2: zone shift
    // An offset of at most 16 hours crosses one day boundary at most.
    always_comb
    begin
        offset   = zone_sel_reg ? zone_b_reg : zone_a_reg;
        hour_sum = $signed({2'b00, hour_reg}) + $signed({{2{offset[4]}}, offset});
        leap_cur = is_leap(year_reg);
        len_cur  = month_len(month_reg, leap_cur);
        len_prev = month_len(month_reg - 4'd1, leap_cur);

        loc.local_year   = year_reg;
        loc.local_month  = month_reg;
        loc.local_day    = day_reg;
        loc.local_hour   = 5'(hour_sum);
        loc.local_minute = minute_reg;
        loc.local_second = second_reg;
        loc.week_day     = '0;
        loc.zone_index   = zone_sel_reg;

        if (hour_sum >= HOURS_PER_DAY)
        begin
            loc.local_hour = 5'(hour_sum - HOURS_PER_DAY);
            if (day_reg >= len_cur)
            begin
                loc.local_day = DAY_FIRST;
                if (month_reg >= MONTH_DEC)
                begin
                    loc.local_month = MONTH_JAN;
                    if (year_reg < YEAR_MAX)
                    begin
                        loc.local_year = year_reg + 14'd1;
                    end
                end
                else
                begin
                    loc.local_month = month_reg + 4'd1;
                end
            end
            else
            begin
                loc.local_day = day_reg + 5'd1;
            end
        end
        else if (hour_sum < 7'sd0)
        begin
            loc.local_hour = 5'(hour_sum + HOURS_PER_DAY);
            if (day_reg <= DAY_FIRST)
            begin
                if (month_reg <= MONTH_JAN)
                begin
                    // borrow into December of the year before, floor at year one
                    loc.local_month = MONTH_DEC;
                    loc.local_day   = DAY_DEC_LEN;
                    if (year_reg > YEAR_MIN)
                    begin
                        loc.local_year = year_reg - 14'd1;
                    end
                end
                else
                begin
                    loc.local_month = month_reg - 4'd1;
                    loc.local_day   = len_prev;
                end
            end
            else
            begin
                loc.local_day = day_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            s2_res_reg <= loc;
        end
    end

    // -------------------------------------------------- stage 3: century divide
    always_comb
    begin
        yy = (s2_res_reg.local_month < MONTH_MAR) ? s2_res_reg.local_year - 14'd1
                                                  : s2_res_reg.local_year;
        q100_prod = 25'(yy[13:2]) * 25'(RECIP25);
    end

    always_ff @(posedge clk)
    begin
        if (s3_load)
        begin
            s3_res_reg  <= s2_res_reg;
            s3_yy_reg   <= yy;
            s3_q100_reg <= q100_prod[RECIP25_SHIFT +: 8];
        end
    end

    // ------------------------------------------------------- stage 4: weekday
    always_comb
    begin
        dow_sum = 15'(s3_yy_reg[13:2]) + 15'(s3_yy_reg) - 15'(s3_q100_reg)
                + 15'(s3_q100_reg[7:2])
                + 15'(MONTH_SHIFT[4'(s3_res_reg.local_month - 4'd1)])
                + 15'(s3_res_reg.local_day);

        // 8 is 1 mod 7: add the octal digits, then once more, then one subtract
        fold1 = 6'(dow_sum[2:0]) + 6'(dow_sum[5:3]) + 6'(dow_sum[8:6])
              + 6'(dow_sum[11:9]) + 6'(dow_sum[14:12]);
        fold2 = 4'(fold1[2:0]) + 4'(fold1[5:3]);
        dow_rem = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : 3'(fold2);

        s4_res_next          = s3_res_reg;
        s4_res_next.week_day = (dow_rem == 3'd0) ? WEEK_SUNDAY : dow_rem;
    end

    always_ff @(posedge clk)
    begin
        if (s4_load)
        begin
            s4_res_reg <= s4_res_next;
        end
    end

    assign result.valid = s4_valid_reg;
    assign result.data  = s4_res_reg;

    // -------------------------------------------------------------- assertions
    a_zone_toggles: assert property (@(posedge clk) disable iff (!rst_n)
        item_fire && (item.data.func == FUNC_ZONE) |=> zone_sel_reg != $past(zone_sel_reg))
        else $error("zone step did not toggle the zone select");

    a_state_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (month_reg >= MONTH_JAN) && (month_reg <= MONTH_DEC) && (day_reg != 5'd0)
        && (hour_reg <= HOUR_MAX) && (year_reg >= YEAR_MIN) && (year_reg <= YEAR_MAX))
        else $error("calendar state left its range");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_ready |-> !item.ready)
        else $error("item taken while state beat is still pending");

    a_second_step: assert property (@(posedge clk) disable iff (!rst_n)
        item_fire && (item.data.func == FUNC_TICK) && (second_reg < MINSEC_MAX)
        |=> (second_reg == $past(second_reg) + 6'd1) && (minute_reg == $past(minute_reg)))
        else $error("tick below the minute boundary carried wrongly");

endmodule
`default_nettype wire

// ===== sim/zone_clock_check_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// zone_clock_check_pkg: local-time tracker for the zoned calendar clock bench
// Mirrors the clock state and zone offsets, predicts the local date, time and
// weekday of every accepted command and checks results in arrival order.
// ----------------------------------------------------------------------------
package zone_clock_check_pkg;
    import cwz_pkg::*;

    localparam logic [1:0] FUNC_UNUSED    = 2'd3;
    localparam logic [2:0] WEEK_WEDNESDAY = 3'd3;
    localparam int         REPORT_LIMIT   = 40;

    typedef struct packed {
        year_t   year;
        month_t  month;
        day_t    day;
        hour_t   hour;
        minsec_t minute;
        minsec_t second;
    } wall_time_t;

    class local_time_tracker;
        wall_time_t  now_time;
        logic [2:0]  weekday;
        logic        zone;
        offset_t     zone_offset [2];
        result_t     local_times_due [$];
        int unsigned failures;

        function new();
            now_time = '{year: YEAR_RESET, month: MONTH_JAN, day: DAY_FIRST,
                         hour: '0, minute: '0, second: '0};
            weekday        = WEEK_WEDNESDAY;
            zone           = 1'b0;
            zone_offset[0] = '0;
            zone_offset[1] = ZONE_B_RESET;
            failures       = 0;
        endfunction

        function day_t month_days(month_t m, year_t y);
            bit leap;
            leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
            case (m)
                4'd2:                    return leap ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
                default:                 return 5'd31;
            endcase
        endfunction

        function logic [2:0] weekday_of(wall_time_t t);
            int unsigned yy;
            int unsigned r;
            // January and February count with the previous year
            yy = (t.month < MONTH_MAR) ? t.year - 1 : t.year;
            r  = (yy / 4 - yy / 100 + yy / 400 + yy
                  + MONTH_SHIFT[4'(t.month - 4'd1)] + t.day) % 7;
            return (r == 0) ? WEEK_SUNDAY : r[2:0];
        endfunction

        function wall_time_t next_hour(wall_time_t t);
            if (t.hour >= HOUR_MAX)
            begin
                if (t.day >= month_days(t.month, t.year))
                begin
                    if (t.month >= MONTH_DEC)
                    begin
                        // hold the year at its top
                        if (t.year < YEAR_MAX)
                            t.year = t.year + 1'b1;
                        t.month = MONTH_JAN;
                    end
                    else
                        t.month = t.month + 1'b1;
                    t.day = DAY_FIRST;
                end
                else
                    t.day = t.day + 1'b1;
                t.hour = '0;
            end
            else
                t.hour = t.hour + 1'b1;
            return t;
        endfunction

        function void set_offset(logic [CFG_IDX_W-1:0] idx, offset_t value);
            zone_offset[idx] = value;
        endfunction

        function int unsigned pending();
            return local_times_due.size();
        endfunction

        function void note_item(item_t it);
            day_t       len;
            int         shift;
            int         steps;
            int         n;
            wall_time_t loc;
            result_t    r;
            case (it.func)
                FUNC_TICK:
                begin
                    if (now_time.second >= MINSEC_MAX)
                    begin
                        now_time.second = '0;
                        if (now_time.minute >= MINSEC_MAX)
                        begin
                            now_time.minute = '0;
                            now_time = next_hour(now_time);
                        end
                        else
                            now_time.minute = now_time.minute + 1'b1;
                    end
                    else
                        now_time.second = now_time.second + 1'b1;
                    weekday = weekday_of(now_time);
                end
                FUNC_LOAD:
                begin
                    // saturate every loaded field into its range
                    now_time.year = (it.load_year < YEAR_MIN) ? YEAR_MIN :
                                    (it.load_year > YEAR_MAX) ? YEAR_MAX : it.load_year;
                    now_time.month = (it.load_month < MONTH_JAN) ? MONTH_JAN :
                                     (it.load_month > MONTH_DEC) ? MONTH_DEC : it.load_month;
                    len = month_days(now_time.month, now_time.year);
                    now_time.day = (it.load_day < DAY_FIRST) ? DAY_FIRST :
                                   (it.load_day > len) ? len : it.load_day;
                    now_time.hour   = (it.load_hour > HOUR_MAX) ? HOUR_MAX : it.load_hour;
                    now_time.minute = (it.load_minute > MINSEC_MAX) ? MINSEC_MAX
                                                                   : it.load_minute;
                    now_time.second = (it.load_second > MINSEC_MAX) ? MINSEC_MAX
                                                                   : it.load_second;
                    weekday = weekday_of(now_time);
                end
                FUNC_ZONE:
                    zone = ~zone;
                default:
                    ;
            endcase

            shift = zone_offset[zone];
            steps = (shift < 0) ? -shift : shift;
            loc   = now_time;
            for (n = 0; n < steps; n++)
            begin
                if (shift >= 0)
                    loc = next_hour(loc);
                else if (loc.hour == '0)
                begin
                    if (loc.day <= DAY_FIRST)
                    begin
                        // hold the year at its bottom
                        if (loc.month <= MONTH_JAN)
                        begin
                            if (loc.year > YEAR_MIN)
                                loc.year = loc.year - 1'b1;
                            loc.month = MONTH_DEC;
                        end
                        else
                            loc.month = loc.month - 1'b1;
                        loc.day = month_days(loc.month, loc.year);
                    end
                    else
                        loc.day = loc.day - 1'b1;
                    loc.hour = HOUR_MAX;
                end
                else
                    loc.hour = loc.hour - 1'b1;
            end

            r.local_year   = loc.year;
            r.local_month  = loc.month;
            r.local_day    = loc.day;
            r.local_hour   = loc.hour;
            r.local_minute = loc.minute;
            r.local_second = loc.second;
            r.week_day     = (steps == 0) ? weekday : weekday_of(loc);
            r.zone_index   = zone;
            local_times_due.push_back(r);
        endfunction

        function void compare_field(string name, logic [13:0] want, logic [13:0] got);
            if (got !== want)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("%0t: %s mismatch, expected %0d, actual %0d",
                             $time, name, want, got);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (local_times_due.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("%0t: unexpected result beat, expected none, actual %h",
                             $time, got);
                return;
            end
            want = local_times_due.pop_front();
            compare_field("local_year",   want.local_year,   got.local_year);
            compare_field("local_month",  want.local_month,  got.local_month);
            compare_field("local_day",    want.local_day,    got.local_day);
            compare_field("local_hour",   want.local_hour,   got.local_hour);
            compare_field("local_minute", want.local_minute, got.local_minute);
            compare_field("local_second", want.local_second, got.local_second);
            compare_field("week_day",     want.week_day,     got.week_day);
            compare_field("zone_index",   want.zone_index,   got.zone_index);
        endfunction
    endclass

endpackage
`default_nettype wire

// ===== sim/testbench.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// testbench: self-checking bench for calendar_clock_with_zones
// Directed calendar corner cases, then phases of random tick, load and zone
// commands under several zone offsets, with bursty input and a stalling
// result side; every result beat is checked against the local-time tracker.
// ----------------------------------------------------------------------------
module testbench;
    import cwz_pkg::*;
    import zone_clock_check_pkg::*;

    localparam int unsigned CYCLE_LIMIT      = 200000;
    localparam int unsigned DRAIN_SLACK      = 8;
    localparam int unsigned LONG_HOLD_CYCLES = 200;
    localparam int unsigned PRESSURE_ITEMS   = 40;
    localparam int unsigned PHASES           = 8;
    localparam int unsigned PHASE_ITEMS      = 110;

    typedef enum int unsigned {RX_STREAM, RX_COIN, RX_COMB, RX_SPARSE} rx_mode_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    bit                    long_hold_req;
    int unsigned           ticks_left;
    int unsigned           cycle_count;

    cwz_item_if   item_ch ();
    cwz_result_if result_ch ();

    local_time_tracker tracker = new();

    calendar_clock_with_zones dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item         (item_ch),
        .result       (result_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Note accepted commands before checking, so a same-edge result finds its entry
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_ch.valid && item_ch.ready)
                tracker.note_item(item_ch.data);
            if (result_ch.valid && result_ch.ready)
                tracker.check_result(result_ch.data);
        end
    end

    initial
    begin : receiver
        rx_mode_t    mode;
        int unsigned left;
        int unsigned phase_cnt;
        bit          hold_done;
        result_ch.ready = 1'b0;
        mode      = RX_STREAM;
        left      = 0;
        phase_cnt = 0;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req && !hold_done)
            begin
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                if (left == 0)
                begin
                    mode = rx_mode_t'($urandom_range(0, 3));
                    left = $urandom_range(20, 80);
                end
                left--;
                phase_cnt++;
                case (mode)
                    RX_STREAM: result_ch.ready <= 1'b1;
                    RX_COIN:   result_ch.ready <= 1'($urandom_range(0, 1));
                    RX_COMB:   result_ch.ready <= (phase_cnt % 5) > 1;
                    default:   result_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    function automatic item_t plain_cmd(logic [1:0] f);
        item_t it;
        it.func        = f;
        it.load_year   = year_t'($urandom);
        it.load_month  = month_t'($urandom);
        it.load_day    = day_t'($urandom);
        it.load_hour   = hour_t'($urandom);
        it.load_minute = minsec_t'($urandom);
        it.load_second = minsec_t'($urandom);
        return it;
    endfunction

    function automatic item_t load_cmd(int unsigned y, int unsigned mo, int unsigned d,
                                       int unsigned h, int unsigned mi, int unsigned s);
        item_t it;
        it.func        = FUNC_LOAD;
        it.load_year   = year_t'(y);
        it.load_month  = month_t'(mo);
        it.load_day    = day_t'(d);
        it.load_hour   = hour_t'(h);
        it.load_minute = minsec_t'(mi);
        it.load_second = minsec_t'(s);
        return it;
    endfunction

    task automatic next_random_item(output item_t it);
        int unsigned pick;
        if (ticks_left != 0)
        begin
            it = plain_cmd(FUNC_TICK);
            ticks_left--;
            return;
        end
        pick = $urandom_range(0, 99);
        if (pick < 40)
            it = plain_cmd(FUNC_TICK);
        else if (pick < 70)
        begin
            // load just short of a rollover, then tick through it
            it = plain_cmd(FUNC_LOAD);
            case ($urandom_range(0, 5))
                0:       it.load_year = YEAR_MIN;
                1:       it.load_year = YEAR_MAX;
                2:       it.load_year = 14'd2000;
                3:       it.load_year = 14'd1900;
                4:       it.load_year = year_t'($urandom_range(1, 2499) * 4);
                default: it.load_year = year_t'($urandom_range(1, 9999));
            endcase
            case ($urandom_range(0, 3))
                0:       it.load_month = MONTH_DEC;
                1:       it.load_month = 4'd2;
                2:       it.load_month = MONTH_JAN;
                default: it.load_month = month_t'($urandom_range(1, 12));
            endcase
            it.load_day    = day_t'($urandom_range(27, 31));
            it.load_hour   = ($urandom_range(0, 3) != 0) ? HOUR_MAX
                                                        : hour_t'($urandom_range(0, 23));
            it.load_minute = ($urandom_range(0, 4) != 0) ? MINSEC_MAX
                                                        : minsec_t'($urandom_range(0, 59));
            it.load_second = minsec_t'($urandom_range(55, 59));
            if ($urandom_range(0, 3) == 0)
            begin
                // early on the first of the month, for borrows across days
                it.load_day  = DAY_FIRST;
                it.load_hour = hour_t'($urandom_range(0, 3));
            end
            ticks_left = $urandom_range(1, 6);
        end
        else if (pick < 82)
            it = plain_cmd(FUNC_LOAD);
        else if (pick < 95)
            it = plain_cmd(FUNC_ZONE);
        else
            it = plain_cmd(FUNC_UNUSED);
    endtask

    task automatic send_item(input item_t it);
        @(negedge clk);
        item_ch.valid <= 1'b1;
        item_ch.data  <= it;
        do
            @(posedge clk);
        while (!item_ch.ready);
    endtask

    task automatic idle_items(input int unsigned cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            item_ch.valid <= 1'b0;
        end
    endtask

    task automatic wait_drained();
        idle_items(1);
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    task automatic write_offset(input logic [CFG_IDX_W-1:0] idx, input offset_t value);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        tracker.set_offset(idx, value);
    endtask

    initial
    begin : stimulus
        item_t       it;
        int unsigned phase;
        int unsigned sent;
        int unsigned burst;
        int unsigned gap;
        item_ch.valid = 1'b0;
        item_ch.data  = '0;
        cfg_write_en  = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        long_hold_req = 1'b0;
        ticks_left    = 0;
        wait (rst_n === 1'b1);

        // reset offsets: zone A none, zone B six hours back
        send_item(plain_cmd(FUNC_TICK));
        send_item(load_cmd(9999, 12, 31, 23, 59, 59));
        send_item(plain_cmd(FUNC_TICK));
        send_item(load_cmd(1, 1, 1, 0, 0, 0));
        send_item(plain_cmd(FUNC_ZONE));
        send_item(plain_cmd(FUNC_ZONE));
        send_item(load_cmd(0, 0, 0, 31, 63, 63));
        send_item(load_cmd(16383, 15, 31, 0, 0, 0));
        send_item(load_cmd(2000, 2, 28, 23, 59, 59));
        send_item(plain_cmd(FUNC_TICK));
        send_item(load_cmd(1900, 2, 28, 23, 59, 59));
        send_item(plain_cmd(FUNC_TICK));
        send_item(load_cmd(2024, 2, 31, 12, 0, 0));
        send_item(load_cmd(2023, 2, 30, 12, 0, 0));
        send_item(plain_cmd(FUNC_UNUSED));
        send_item(load_cmd(2021, 4, 30, 23, 59, 59));
        send_item(plain_cmd(FUNC_TICK));
        wait_drained();

        // widest offsets the register holds
        write_offset(REG_ZONE_A, 5'sd15);
        write_offset(REG_ZONE_B, -5'sd16);
        send_item(load_cmd(9999, 12, 31, 20, 0, 0));
        send_item(plain_cmd(FUNC_ZONE));
        send_item(load_cmd(1, 1, 1, 5, 0, 0));
        send_item(load_cmd(2024, 3, 1, 10, 0, 0));
        send_item(plain_cmd(FUNC_ZONE));
        send_item(load_cmd(2023, 12, 31, 10, 0, 0));
        send_item(plain_cmd(FUNC_TICK));
        wait_drained();

        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    write_offset(REG_ZONE_A, 5'sd0);
                    write_offset(REG_ZONE_B, 5'sd0);
                end
                1:
                begin
                    write_offset(REG_ZONE_A, -5'sd12);
                    write_offset(REG_ZONE_B, 5'sd14);
                end
                2:
                begin
                    write_offset(REG_ZONE_A, offset_t'($urandom_range(0, 14)));
                    write_offset(REG_ZONE_B, -offset_t'($urandom_range(1, 12)));
                end
                3:
                begin
                    write_offset(REG_ZONE_A, -5'sd16);
                    write_offset(REG_ZONE_B, 5'sd15);
                end
                default:
                begin
                    write_offset(REG_ZONE_A, offset_t'($urandom_range(0, 31)));
                    write_offset(REG_ZONE_B, offset_t'($urandom_range(0, 31)));
                end
            endcase

            sent = 0;
            if (phase == 2)
            begin
                // keep offering while results are held back, so the input backs up
                long_hold_req = 1'b1;
                for (burst = 0; burst < PRESSURE_ITEMS; burst++)
                begin
                    next_random_item(it);
                    send_item(it);
                end
                sent = PRESSURE_ITEMS;
            end

            while (sent < PHASE_ITEMS)
            begin
                burst = $urandom_range(1, 24);
                while (burst != 0 && sent < PHASE_ITEMS)
                begin
                    next_random_item(it);
                    send_item(it);
                    burst--;
                    sent++;
                end
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                idle_items(gap);
            end
            wait_drained();
        end

        if (tracker.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
`default_nettype wire
